@@ rtl/core/qtd_pkg.sv @@
// Shared types, constants and helper functions of the quadtree decomposition block.
`timescale 1ns / 1ps
`default_nettype none
package qtd_pkg;

   // Grid geometry.
   localparam int GRID_LOG  = 7;
   localparam int GRID_SIDE = 1 << GRID_LOG;
   localparam int DEPTH_W   = $clog2(GRID_LOG + 1);
   localparam int LVL_W     = (GRID_LOG > 2) ? $clog2(GRID_LOG) : 1;
   localparam int CNT_W     = GRID_LOG + 1;

   // Fixed widths of the port fields.
   localparam int FIELD_W      = 7;
   localparam int SIZE_FIELD_W = 3;

   typedef logic [GRID_LOG-1:0]     coord_type;
   typedef logic [GRID_SIDE-1:0]    row_bits_type;
   typedef logic [DEPTH_W-1:0]      depth_type;
   typedef logic [FIELD_W-1:0]      field_type;
   typedef logic [SIZE_FIELD_W-1:0] size_field_type;
   typedef logic [1:0]              quad_type;

   // Request function codes.
   localparam logic FUNC_MARK = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   // Quadrant codes in visiting order.
   localparam quad_type Q_TR = 2'd0;
   localparam quad_type Q_TL = 2'd1;
   localparam quad_type Q_BR = 2'd2;
   localparam quad_type Q_BL = 2'd3;

   typedef enum logic [1:0] {
      KIND_MARK = 2'd0,
      KIND_BOX  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   // Command from the sequencer to the square scanner.
   typedef struct packed {
      logic      start;
      coord_type row;
      coord_type col;
      depth_type size_log;
   } scan_req_type;

   // Status from the square scanner.
   typedef struct packed {
      logic done;
      logic empty;
      logic full;
   } scan_stat_type;

   // Port field to grid coordinate: low bits kept, zero extended on wide grids.
   function automatic coord_type coord_from_field(input field_type f);
      coord_type c;
      c = '0;
      for (int i = 0; i < GRID_LOG; i++) begin
         if (i < FIELD_W) begin
            c[i] = f[i];
         end
      end
      return c;
   endfunction

   // Grid coordinate to port field, masked to the field width.
   function automatic field_type field_from_coord(input coord_type c);
      field_type f;
      f = '0;
      for (int i = 0; i < FIELD_W; i++) begin
         if (i < GRID_LOG) begin
            f[i] = c[i];
         end
      end
      return f;
   endfunction

   // Square size log as a port field, masked to the field width.
   function automatic size_field_type size_field(input depth_type d);
      size_field_type f;
      f = '0;
      for (int i = 0; i < SIZE_FIELD_W; i++) begin
         if (i < DEPTH_W) begin
            f[i] = d[i];
         end
      end
      return f;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/quadtree_full_square_decomposition.sv @@
// Top level of the quadtree full-square decomposition block.
// A mark passes through the S_MARK and S_DELIV states and then the output register before
// its result is valid. A pull walks the quadtree one square at a time; each visited square
// is read by the row scanner, which reads one bitmap row per cycle from a single-port RAM.
// Row valid bits clear the map at frame done; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module quadtree_full_square_decomposition (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_func,
   input  wire qtd_pkg::field_type       req_pixel_row,
   input  wire qtd_pkg::field_type       req_pixel_col,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output qtd_pkg::field_type            rsp_box_row,
   output qtd_pkg::field_type            rsp_box_col,
   output qtd_pkg::size_field_type       rsp_box_size_log
);
   import qtd_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MARK  = 7'b0000010,
      S_START = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_ADV   = 7'b0100000,
      S_DELIV = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic             active_ff, active_in;
   depth_type        depth_ff, depth_in;
   quad_type         path_ff [GRID_LOG];
   quad_type         path_in [GRID_LOG];
   row_bits_type     row_valid_ff, row_valid_in;
   logic             rd_ok_ff;
   coord_type        mark_row_ff, mark_row_in;
   coord_type        mark_col_ff, mark_col_in;
   logic             report_ff, report_in;
   kind_type         res_kind_ff, res_kind_in;
   coord_type        res_row_ff, res_row_in;
   coord_type        res_col_ff, res_col_in;
   depth_type        res_size_ff, res_size_in;
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff;
   field_type        rsp_row_ff, rsp_col_ff;
   size_field_type   rsp_size_ff;
   logic             rsp_load;

   logic             ram_we;
   coord_type        ram_addr;
   row_bits_type     ram_wdata, ram_rdata, data_eff;
   coord_type        scan_addr;
   scan_req_type     scan_req;
   scan_stat_type    scan_stat;
   coord_type        pos_row, pos_col;
   depth_type        size_log;
   logic [LVL_W-1:0] top_lvl, push_lvl;

   qtd_ram #(
      .WIDTH(GRID_SIDE),
      .DEPTH(GRID_SIDE)
   ) u_map (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   qtd_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .rdata    (data_eff),
      .rd_addr  (scan_addr),
      .scan_stat(scan_stat)
   );

   // Rows never written since the last clear read as empty.
   assign data_eff = ram_rdata & {GRID_SIDE{rd_ok_ff}};

   // Square position from the path: bit 1 of a quadrant code is the lower half,
   // bit 0 clear is the right half.
   always_comb begin
      pos_row = '0;
      pos_col = '0;
      for (int i = 0; i < GRID_LOG; i++) begin
         if (DEPTH_W'(i) < depth_ff) begin
            pos_row[GRID_LOG-1-i] = path_ff[i][1];
            pos_col[GRID_LOG-1-i] = !path_ff[i][0];
         end
      end
   end

   assign size_log = DEPTH_W'(GRID_LOG) - depth_ff;
   assign top_lvl  = LVL_W'(depth_ff - DEPTH_W'(1));
   assign push_lvl = LVL_W'(depth_ff);
   assign rsp_load = (state_ff == S_DELIV) && (!rsp_valid_ff || !rsp_stall);

   // RAM port sharing between the mark path and the scanner.
   always_comb begin
      case (state_ff)
         S_IDLE:  ram_addr = coord_from_field(req_pixel_row);
         S_MARK:  ram_addr = mark_row_ff;
         default: ram_addr = scan_addr;
      endcase
   end

   assign ram_we    = (state_ff == S_MARK);
   assign ram_wdata = data_eff | (row_bits_type'(1) << mark_col_ff);

   // Walk sequencer.
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      depth_in       = depth_ff;
      path_in        = path_ff;
      row_valid_in   = row_valid_ff;
      mark_row_in    = mark_row_ff;
      mark_col_in    = mark_col_ff;
      report_in      = report_ff;
      res_kind_in    = res_kind_ff;
      res_row_in     = res_row_ff;
      res_col_in     = res_col_ff;
      res_size_in    = res_size_ff;
      scan_req       = '0;
      scan_req.row   = pos_row;
      scan_req.col   = pos_col;
      scan_req.size_log = size_log;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_MARK) begin
                  mark_row_in = coord_from_field(req_pixel_row);
                  mark_col_in = coord_from_field(req_pixel_col);
                  state_in    = S_MARK;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_MARK: begin
            row_valid_in[mark_row_ff] = 1'b1;
            res_kind_in = KIND_MARK;
            res_row_in  = '0;
            res_col_in  = '0;
            res_size_in = '0;
            state_in    = S_DELIV;
         end
         S_START: begin
            if (!active_ff) begin
               active_in  = 1'b1;
               depth_in   = DEPTH_W'(1);
               path_in[0] = Q_TR;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (depth_ff == '0) begin
               // Walk over: frame done clears the map and the walk.
               row_valid_in = '0;
               for (int i = 0; i < GRID_LOG; i++) begin
                  path_in[i] = Q_TR;
               end
               active_in   = 1'b0;
               res_kind_in = KIND_DONE;
               res_row_in  = '0;
               res_col_in  = '0;
               res_size_in = '0;
               state_in    = S_DELIV;
            end else begin
               scan_req.start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_stat.done) begin
               if (scan_stat.full) begin
                  res_kind_in = KIND_BOX;
                  res_row_in  = pos_row;
                  res_col_in  = pos_col;
                  res_size_in = size_log;
                  report_in   = 1'b1;
                  state_in    = S_ADV;
               end else if (!scan_stat.empty && depth_ff < DEPTH_W'(GRID_LOG)) begin
                  path_in[push_lvl] = Q_TR;
                  depth_in          = depth_ff + DEPTH_W'(1);
                  state_in          = S_CHECK;
               end else begin
                  report_in = 1'b0;
                  state_in  = S_ADV;
               end
            end
         end
         S_ADV: begin
            // Climb one level per cycle past finished squares, then step sideways.
            if (depth_ff != '0 && path_ff[top_lvl] == Q_BL) begin
               depth_in = depth_ff - DEPTH_W'(1);
            end else begin
               if (depth_ff != '0) begin
                  path_in[top_lvl] = path_ff[top_lvl] + quad_type'(1);
               end
               state_in = report_ff ? S_DELIV : S_CHECK;
            end
         end
         S_DELIV: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         depth_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < GRID_LOG; i++) begin
            path_ff[i] <= Q_TR;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         depth_ff     <= depth_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         path_ff      <= path_in;
      end
      rd_ok_ff    <= row_valid_ff[ram_addr];
      mark_row_ff <= mark_row_in;
      mark_col_ff <= mark_col_in;
      report_ff   <= report_in;
      res_kind_ff <= res_kind_in;
      res_row_ff  <= res_row_in;
      res_col_ff  <= res_col_in;
      res_size_ff <= res_size_in;
      if (rsp_load) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_row_ff  <= field_from_coord(res_row_ff);
         rsp_col_ff  <= field_from_coord(res_col_ff);
         rsp_size_ff <= size_field(res_size_ff);
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_box_row      = rsp_row_ff;
   assign rsp_box_col      = rsp_col_ff;
   assign rsp_box_size_log = rsp_size_ff;

endmodule
`default_nettype wire

@@ rtl/core/qtd_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module qtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read on one port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/qtd_scan.sv @@
// Square scanner: reads one bitmap row per cycle and reports empty or full.
`timescale 1ns / 1ps
`default_nettype none
module qtd_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qtd_pkg::scan_req_type scan_req,
   input  wire qtd_pkg::row_bits_type rdata,
   output qtd_pkg::coord_type         rd_addr,
   output qtd_pkg::scan_stat_type     scan_stat
);
   import qtd_pkg::*;

   logic             busy_ff, busy_in;
   logic             pend_ff, pend_in;
   logic             last_ff, last_in;
   logic             any_ff, any_in;
   logic             all_ff, all_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   depth_type        sl_ff, sl_in;
   coord_type        row_ff, row_in;
   row_bits_type     mask_ff, mask_in;
   row_bits_type     seg;
   logic             seg_any, seg_all;
   logic [CNT_W-1:0] side_m1;

   assign side_m1 = (CNT_W'(1) << sl_ff) - CNT_W'(1);
   assign rd_addr = row_ff + cnt_ff[GRID_LOG-1:0];

   // Column window of the row just read.
   assign seg     = rdata & mask_ff;
   assign seg_any = |seg;
   assign seg_all = (seg == mask_ff);

   assign scan_stat.done  = pend_ff & last_ff;
   assign scan_stat.empty = !(any_ff | seg_any);
   assign scan_stat.full  = all_ff & seg_all;

   // Row issue and accumulation.
   always_comb begin
      busy_in = busy_ff;
      pend_in = 1'b0;
      last_in = 1'b0;
      any_in  = any_ff;
      all_in  = all_ff;
      cnt_in  = cnt_ff;
      sl_in   = sl_ff;
      row_in  = row_ff;
      mask_in = mask_ff;
      if (pend_ff) begin
         any_in = any_ff | seg_any;
         all_in = all_ff & seg_all;
      end
      if (scan_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sl_in   = scan_req.size_log;
         row_in  = scan_req.row;
         any_in  = 1'b0;
         all_in  = 1'b1;
         for (int j = 0; j < GRID_SIDE; j++) begin
            mask_in[j] = ((coord_type'(j) ^ scan_req.col) >> scan_req.size_log) == '0;
         end
      end else if (busy_ff) begin
         pend_in = 1'b1;
         last_in = (cnt_ff == side_m1);
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == side_m1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         last_ff <= last_in;
      end
      any_ff  <= any_in;
      all_ff  <= all_in;
      cnt_ff  <= cnt_in;
      sl_ff   <= sl_in;
      row_ff  <= row_in;
      mask_ff <= mask_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/qtd_checker.sv @@
// Port-level checks of the quadtree decomposition block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qtd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [1:0]                    rsp_result_kind,
   input wire qtd_pkg::field_type            rsp_box_row,
   input wire qtd_pkg::field_type            rsp_box_col,
   input wire qtd_pkg::size_field_type       rsp_box_size_log
);
   import qtd_pkg::*;

   // A stalled response stays valid.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its kind.
   a_hold_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result_kind))
      else $error("response kind changed while stalled");

   // Mark and frame-done responses carry no box.
   a_no_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_BOX |->
         rsp_box_row == '0 && rsp_box_col == '0 && rsp_box_size_log == '0)
      else $error("box fields set on a non-box response");

   // A reported box is aligned to its own size.
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_BOX |->
         ((rsp_box_row | rsp_box_col) & ((field_type'(1) << rsp_box_size_log) - field_type'(1)))
            == '0)
      else $error("box not aligned to its size");

endmodule

bind quadtree_full_square_decomposition qtd_checker u_qtd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_box_row     (rsp_box_row),
   .rsp_box_col     (rsp_box_col),
   .rsp_box_size_log(rsp_box_size_log)
);
`default_nettype wire
